@@ rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512/256 package
// Payload types, initial values, round constants and block command codes.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Block command: what the back end does once the block is compressed
    typedef enum logic [0:0] {
        CMD_CHAIN  = 1'b0,
        CMD_DIGEST = 1'b1
    } t_cmd;

    // Front-to-back queue entry: one full 128-byte block and its command
    typedef struct packed {
        logic [1023:0] block;
        t_cmd          cmd;
    } t_blk;

    localparam logic [60:0] COUNT_MAX = {61{1'b1}};
    localparam int unsigned ROUNDS = 80;

    localparam logic [63:0] INIT_VALUE [8] = '{
        64'h22312194FC2BF72C, 64'h9F555FA3C84C64C2,
        64'h2393B86B6F53B151, 64'h963877195940EABD,
        64'h96283EE2A88EFFE3, 64'hBE5E1E2553863992,
        64'h2B0199FC2C85B8AA, 64'h0EB72DDC81C52CA2
    };

    localparam logic [63:0] ROUND_CONST [80] = '{
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F,
        64'hE9B5DBA58189DBBC, 64'h3956C25BF348B538, 64'h59F111F1B605D019,
        64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118, 64'hD807AA98A3030242,
        64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235,
        64'hC19BF174CF692694, 64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3,
        64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65, 64'h2DE92C6F592B0275,
        64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F,
        64'hBF597FC7BEEF0EE4, 64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725,
        64'h06CA6351E003826F, 64'h142929670A0E6E70, 64'h27B70A8546D22FFC,
        64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6,
        64'h92722C851482353B, 64'hA2BFE8A14CF10364, 64'hA81A664BBC423001,
        64'hC24B8B70D0F89791, 64'hC76C51A30654BE30, 64'hD192E819D6EF5218,
        64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99,
        64'h34B0BCB5E19B48A8, 64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB,
        64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3, 64'h748F82EE5DEFB2FC,
        64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915,
        64'hC67178F2E372532B, 64'hCA273ECEEA26619C, 64'hD186B8C721C0C207,
        64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178, 64'h06F067AA72176FBA,
        64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC,
        64'h431D67C49C100D4C, 64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A,
        64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

@@ rtl/sha_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512/256 front end
// Gathers bytes into a block register, pads the message tail and pushes
// finished blocks with their command into the block queue.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha_pkg::t_in_item i_in,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output sha_pkg::t_blk    o_blk,
    output logic             o_blk_valid,
    input  logic             i_blk_ready
);

    typedef enum logic [1:0] {
        S_FILL,
        S_PAD_PUSH,
        S_LEN_PUSH
    } t_state;

    t_state        r_state;
    logic [1023:0] r_blk;
    logic [60:0]   r_count;
    logic          r_push;
    logic          r_push_digest;
    logic [6:0]    r_pos;
    logic [1023:0] w_pad_blk;
    logic [1023:0] w_len_blk;
    logic [6:0]    w_pos;
    logic          w_take;
    logic          w_store;
    logic [63:0]   w_bits;

    assign o_blk       = '{block: r_blk,
                           cmd: r_push_digest ? sha_pkg::CMD_DIGEST : sha_pkg::CMD_CHAIN};
    assign o_blk_valid = r_push;
    assign o_in_ready  = (r_state == S_FILL) && !r_push;
    assign w_take      = i_in_valid && o_in_ready;
    assign w_store     = w_take && i_in.has_byte && (r_count != sha_pkg::COUNT_MAX);
    assign w_pos       = r_count[6:0];
    assign w_bits      = {r_count, 3'b000};

    // Pad marker, zero tail, and the length when it fits in this block
    always_comb begin
        w_pad_blk = r_blk;
        for (int b = 0; b < 128; b++) begin
            if (b == int'(r_pos)) begin
                w_pad_blk[1023 - 8*b -: 8] = 8'h80;
            end else if (b > int'(r_pos)) begin
                w_pad_blk[1023 - 8*b -: 8] = 8'h00;
            end
        end
        if (r_pos < 7'd112) begin
            w_pad_blk[63:0] = w_bits;
        end
    end

    // Length-only block when the pad spilled over
    assign w_len_blk = {960'd0, w_bits};

    // Fill, pad and push blocks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_count       <= '0;
            r_push        <= 1'b0;
            r_push_digest <= 1'b0;
            r_pos         <= '0;
        end else begin
            if (r_push && i_blk_ready) begin
                r_push <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    if (w_take) begin
                        if (w_store) begin
                            r_blk[{~w_pos, 3'b111} -: 8] <= i_in.message_byte;
                            r_count                      <= r_count + 61'd1;
                        end
                        if (w_store && w_pos == 7'd127) begin
                            // full block first; tail handled afterwards
                            r_push        <= 1'b1;
                            r_push_digest <= 1'b0;
                            if (i_in.end_of_message) begin
                                r_pos   <= '0;
                                r_state <= S_PAD_PUSH;
                            end
                        end else if (i_in.end_of_message) begin
                            r_pos   <= w_store ? w_pos + 7'd1 : w_pos;
                            r_state <= S_PAD_PUSH;
                        end
                    end
                end
                S_PAD_PUSH: begin
                    if (!r_push) begin
                        r_blk  <= w_pad_blk;
                        r_push <= 1'b1;
                        if (r_pos < 7'd112) begin
                            r_push_digest <= 1'b1;
                            r_count       <= '0;
                            r_state       <= S_FILL;
                        end else begin
                            r_push_digest <= 1'b0;
                            r_state       <= S_LEN_PUSH;
                        end
                    end
                end
                S_LEN_PUSH: begin
                    if (!r_push) begin
                        r_blk         <= w_len_blk;
                        r_push        <= 1'b1;
                        r_push_digest <= 1'b1;
                        r_count       <= '0;
                        r_state       <= S_FILL;
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

endmodule

@@ rtl/sha_blk_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512/256 block queue
// Two-entry queue of blocks between the front and back ends.
// ----------------------------------------------------------------------------
module sha_blk_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sha_pkg::t_blk i_blk,
    input  logic          i_valid,
    output logic          o_ready,
    output sha_pkg::t_blk o_blk,
    output logic          o_valid,
    input  logic          i_ready
);

    sha_pkg::t_blk r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_blk   = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr] <= i_blk;
                r_wr        <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ rtl/sha_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512/256 back end
// Runs the 80-round compression one round per cycle and emits the digest
// words straight from the chaining registers.
// ----------------------------------------------------------------------------
module sha_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha_pkg::t_blk     i_blk,
    input  logic              i_blk_valid,
    output logic              o_blk_ready,
    output sha_pkg::t_out_item o_out,
    output logic              o_out_valid,
    input  logic              i_out_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    t_state       r_state;
    logic [63:0]  r_h [8];
    logic [63:0]  r_v [8];
    logic [63:0]  r_w [16];
    logic [6:0]   r_round;
    sha_pkg::t_cmd r_cmd;
    logic [1:0]   r_idx;
    logic [63:0]  w_wt;
    logic [63:0]  w_t1;
    logic [63:0]  w_t2;
    logic [63:0]  w_s0;
    logic [63:0]  w_s1;

    assign o_blk_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out       = '{digest_word: r_h[r_idx], word_index: r_idx,
                           last_word: (r_idx == 2'd3)};

    // Message schedule from a sliding window (r_w[0] is current word)
    always_comb begin
        w_s0 = sha_pkg::rotr(r_w[1], 1) ^ sha_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        w_s1 = sha_pkg::rotr(r_w[14], 19) ^ sha_pkg::rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        w_wt = r_w[0];
        w_t1 = r_v[7]
             + (sha_pkg::rotr(r_v[4], 14) ^ sha_pkg::rotr(r_v[4], 18)
                ^ sha_pkg::rotr(r_v[4], 41))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha_pkg::ROUND_CONST[r_round] + w_wt;
        w_t2 = (sha_pkg::rotr(r_v[0], 28) ^ sha_pkg::rotr(r_v[0], 34)
                ^ sha_pkg::rotr(r_v[0], 39))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // Sequence rounds, chaining update and digest output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_round <= '0;
            r_idx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::INIT_VALUE[i];
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_blk_valid) begin
                        for (int i = 0; i < 16; i++) begin
                            r_w[i] <= i_blk.block[1023 - 64*i -: 64];
                        end
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_h[i];
                        end
                        r_cmd   <= i_blk.cmd;
                        r_round <= '0;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    // window index 16 relative: w[t+16] = s1(w14)+w9+s0(w1)+w0
                    r_w[15] <= w_s1 + r_w[9] + w_s0 + r_w[0];
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    if (r_round == 7'(sha_pkg::ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_idx   <= '0;
                    r_state <= (r_cmd == sha_pkg::CMD_DIGEST) ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_idx <= r_idx + 2'd1;
                        if (r_idx == 2'd3) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha_pkg::INIT_VALUE[i];
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/sha512_256_hash.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512/256 hash engine
// Byte-serial SHA-512/256 with a front end that gathers and pads blocks, a
// two-block queue, and a round-per-cycle compression back end.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while filling, pausing while a full block
//   is pushed; the back end loads a block, runs 80 rounds and a chaining add
//   before it takes the next. The first digest word follows the last block,
//   which is a second, length-only block when padding spills over.
// Reset: synchronous active-low; restores the initial chaining values and
//   clears counts and queue; the engine also returns there after each digest.
module sha512_256_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_in_item  i_in,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output sha_pkg::t_out_item o_out,
    output logic               o_out_valid,
    input  logic               i_out_ready
);

    sha_pkg::t_blk w_f_blk;
    logic          w_f_valid;
    logic          w_f_ready;
    sha_pkg::t_blk w_b_blk;
    logic          w_b_valid;
    logic          w_b_ready;

    sha_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_blk       (w_f_blk),
        .o_blk_valid (w_f_valid),
        .i_blk_ready (w_f_ready)
    );

    sha_blk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (w_f_blk),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .o_blk   (w_b_blk),
        .o_valid (w_b_valid),
        .i_ready (w_b_ready)
    );

    sha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk       (w_b_blk),
        .i_blk_valid (w_b_valid),
        .o_blk_ready (w_b_ready),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule
